/* sv/ethernet_flow_tuple_extractor_core_defines.svh */
// assertion macros for the flow tuple extractor checker
`ifndef ETHERNET_FLOW_TUPLE_EXTRACTOR_CORE_DEFINES_SVH
`define ETHERNET_FLOW_TUPLE_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define EFTX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define EFTX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/eftx_pkg.sv */
// shared types and constants for the ethernet flow tuple extractor
package eftx_pkg;

  localparam int ETH_HDR_BYTES = 14;
  localparam int STORE_DEPTH   = 58;
  localparam int IDX_W         = $clog2(STORE_DEPTH);
  localparam int IP4_HDR_BYTES = 20;
  localparam int IP6_HDR_BYTES = 40;
  localparam int TCP_HDR_BYTES = 20;
  localparam int UDP_HDR_BYTES = 8;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_SHORT      = 3'd1,
    ST_ETHERTYPE  = 3'd2,
    ST_PROTOCOL   = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_NO_PAYLOAD = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FLOW_V4_TCP = 2'd0,
    FLOW_V4_UDP = 2'd1,
    FLOW_V6_TCP = 2'd2,
    FLOW_V6_UDP = 2'd3
  } flow_t;

  typedef logic [STORE_DEPTH-1:0][7:0] hdr_t;

  // one finished frame, handed from the front to the back
  typedef struct packed {
    hdr_t        hdr;
    logic        short_frame;
    logic [15:0] wire_length;
  } frame_rec_t;

  typedef struct packed {
    status_t     status;
    flow_t       flow_type;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [63:0] source_ip_high;
    logic [63:0] source_ip_low;
    logic [63:0] dest_ip_high;
    logic [63:0] dest_ip_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] app_payload_length;
    logic [15:0] frame_wire_length;
  } result_t;

endpackage

/* sv/eftx_in_if.sv */
// request channel carrying frame bytes
interface eftx_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] wire_length;

  modport source (output valid, output data_byte, output last_byte, output wire_length,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input wire_length,
                  output ready);
endinterface

/* sv/eftx_out_if.sv */
// result channel carrying one verdict per frame
interface eftx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  flow_type;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [63:0] source_ip_high;
  logic [63:0] source_ip_low;
  logic [63:0] dest_ip_high;
  logic [63:0] dest_ip_low;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] app_payload_length;
  logic [15:0] frame_wire_length;

  modport source (output valid, output status, output flow_type, output dest_mac,
                  output source_mac, output source_ip_high, output source_ip_low,
                  output dest_ip_high, output dest_ip_low, output source_port,
                  output dest_port, output app_payload_length, output frame_wire_length,
                  input ready);
  modport sink   (input valid, input status, input flow_type, input dest_mac,
                  input source_mac, input source_ip_high, input source_ip_low,
                  input dest_ip_high, input dest_ip_low, input source_port,
                  input dest_port, input app_payload_length, input frame_wire_length,
                  output ready);
endinterface

/* sv/ethernet_flow_tuple_extractor_core.sv */
// Ethernet flow tuple extractor: one verdict and flow tuple per captured frame.
// in_if carries one frame byte per request, with last_byte on the final byte and
// the wire length sampled on the first byte. in_if.ready stays high as long as the
// two-record frame queue has room, so bytes stream in at one per cycle.
// out_if carries one result per frame: status, flow type, MACs, IP addresses,
// ports, payload length and the wire length. A result request is offered once the
// frame record has passed the queue write and then the verdict register; it waits
// in the queue while an earlier result is still stalled.
// Throughput is one byte per cycle and up to one frame per cycle while the queue
// has room; the output register and the queue let a new frame finish while a
// result still waits. When out_if.ready is low the result holds; up to two further
// finished frames wait in the queue, then in_if.ready drops until one is taken.
// Reset (rst_n low, synchronous) empties the queue, drops any result and clears
// the byte count and captured-byte marks; header bytes not yet captured read as zero.
module ethernet_flow_tuple_extractor_core
  import eftx_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic       clk,
  input  logic       rst_n,
  eftx_in_if.sink    in_if,
  eftx_out_if.source out_if
);

  logic       rec_push;
  frame_rec_t rec;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;
  frame_rec_t head_rec;

  eftx_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full   (q_full),
    .rec_push (rec_push),
    .rec      (rec)
  );

  eftx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (rec_push),
    .push_rec   (rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  eftx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (q_pop),
    .out_if     (out_if)
  );

endmodule

/* sv/eftx_front.sv */
// byte capture: header store, byte count and frame record hand-off
module eftx_front
  import eftx_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic       clk,
  input  logic       rst_n,
  eftx_in_if.sink    in_if,
  input  logic       q_full,
  output logic       rec_push,
  output frame_rec_t rec
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [CNT_W-1:0]            count_r;
  logic [15:0]                 wire_r;
  hdr_t                        store_r;
  logic [STORE_DEPTH-1:0]      vld_r;
  logic                        accept;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_idx;
  hdr_t                        cur_hdr;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign wr_en       = accept && (count_r < CNT_W'(STORE_DEPTH));
  assign wr_idx      = count_r[IDX_W-1:0];

  // header as it stands after this byte; bytes not captured this frame read as zero
  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (wr_en && (wr_idx == IDX_W'(k))) begin
        cur_hdr[k] = in_if.data_byte;
      end else if (vld_r[k]) begin
        cur_hdr[k] = store_r[k];
      end else begin
        cur_hdr[k] = 8'h00;
      end
    end
  end

  assign rec_push        = accept && in_if.last_byte;
  assign rec.hdr         = cur_hdr;
  assign rec.short_frame = count_r < CNT_W'(ETH_HDR_BYTES - 1);
  assign rec.wire_length = (count_r == '0) ? in_if.wire_length : wire_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wire_r  <= '0;
      vld_r   <= '0;
    end else if (accept) begin
      if (count_r == '0) begin
        wire_r <= in_if.wire_length;
      end
      if (in_if.last_byte) begin
        count_r <= '0;
        vld_r   <= '0;
      end else begin
        if (count_r < CNT_W'(MAX_FRAME_BYTES)) begin
          count_r <= count_r + 1'b1;
        end
        if (wr_en) begin
          vld_r[wr_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= in_if.data_byte;
    end
  end

endmodule

/* sv/eftx_queue.sv */
// two-entry queue of frame records between capture and verdict
module eftx_queue
  import eftx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output frame_rec_t head_rec
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full       = cnt_r == CNT_W'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

/* sv/eftx_back.sv */
// verdict and field extraction with registered result output
module eftx_back
  import eftx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  frame_rec_t head_rec,
  output logic       pop,
  eftx_out_if.source out_if
);

  logic                valid_r;
  result_t             res_r;
  result_t             res_nxt;
  logic                load;
  logic [15:0]         ethertype;
  logic                is_v4;
  logic                is_v6;
  logic [7:0]          proto;
  logic                is_tcp;
  logic                is_udp;
  logic signed [17:0]  rem;
  logic signed [17:0]  app;
  logic                trunc;
  logic [15:0]         ip_len;

  // big-endian read of n bytes starting at off
  function automatic logic [63:0] rd_be(input hdr_t h, input int off, input int n);
    logic [63:0]      v;
    logic [IDX_W-1:0] k;
    v = '0;
    for (int i = 0; i < n; i++) begin
      k = IDX_W'(off + i);
      v = {v[55:0], h[k]};
    end
    return v;
  endfunction

  assign load = head_valid && (!valid_r || out_if.ready);
  assign pop  = load;

  always_comb begin
    ethertype = 16'(rd_be(head_rec.hdr, 12, 2));
    is_v4     = ethertype == ETYPE_IPV4;
    is_v6     = ethertype == ETYPE_IPV6;
    proto     = is_v6 ? head_rec.hdr[ETH_HDR_BYTES + 6] : head_rec.hdr[ETH_HDR_BYTES + 9];
    is_tcp    = proto == PROTO_TCP;
    is_udp    = proto == PROTO_UDP;
    // ipv6 payload length or ipv4 total length
    ip_len    = is_v6 ? 16'(rd_be(head_rec.hdr, ETH_HDR_BYTES + 4, 2))
                      : 16'(rd_be(head_rec.hdr, ETH_HDR_BYTES + 2, 2));
    rem       = $signed({2'b00, head_rec.wire_length})
              - (is_v6 ? 18'sd54 : 18'sd34);
    trunc     = is_v6 ? (rem < $signed({2'b00, ip_len}))
                      : ((rem + 18'sd20) < $signed({2'b00, ip_len}));
    app       = rem - (is_tcp ? 18'sd20 : 18'sd8);
  end

  always_comb begin
    res_nxt                   = '0;
    res_nxt.status            = ST_ACCEPTED;
    res_nxt.frame_wire_length = head_rec.wire_length;
    if (head_rec.short_frame) begin
      res_nxt.status = ST_SHORT;
    end else if (!is_v4 && !is_v6) begin
      res_nxt.status = ST_ETHERTYPE;
    end else if (rem <= 18'sd0) begin
      res_nxt.status = ST_NO_PAYLOAD;
    end else if (trunc) begin
      res_nxt.status = ST_TRUNCATED;
    end else if (!is_tcp && !is_udp) begin
      res_nxt.status = ST_PROTOCOL;
    end else if (app <= 18'sd0) begin
      res_nxt.status = ST_NO_PAYLOAD;
    end else begin
      res_nxt.flow_type          = flow_t'({is_v6, is_udp});
      res_nxt.dest_mac           = 48'(rd_be(head_rec.hdr, 0, 6));
      res_nxt.source_mac         = 48'(rd_be(head_rec.hdr, 6, 6));
      res_nxt.app_payload_length = app[15:0];
      if (is_v6) begin
        res_nxt.source_ip_high = rd_be(head_rec.hdr, 22, 8);
        res_nxt.source_ip_low  = rd_be(head_rec.hdr, 30, 8);
        res_nxt.dest_ip_high   = rd_be(head_rec.hdr, 38, 8);
        res_nxt.dest_ip_low    = rd_be(head_rec.hdr, 46, 8);
        res_nxt.source_port    = 16'(rd_be(head_rec.hdr, 54, 2));
        res_nxt.dest_port      = 16'(rd_be(head_rec.hdr, 56, 2));
      end else begin
        res_nxt.source_ip_low  = rd_be(head_rec.hdr, 26, 4);
        res_nxt.dest_ip_low    = rd_be(head_rec.hdr, 30, 4);
        res_nxt.source_port    = 16'(rd_be(head_rec.hdr, 34, 2));
        res_nxt.dest_port      = 16'(rd_be(head_rec.hdr, 36, 2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid              = valid_r;
  assign out_if.status             = res_r.status;
  assign out_if.flow_type          = res_r.flow_type;
  assign out_if.dest_mac           = res_r.dest_mac;
  assign out_if.source_mac         = res_r.source_mac;
  assign out_if.source_ip_high     = res_r.source_ip_high;
  assign out_if.source_ip_low      = res_r.source_ip_low;
  assign out_if.dest_ip_high       = res_r.dest_ip_high;
  assign out_if.dest_ip_low        = res_r.dest_ip_low;
  assign out_if.source_port        = res_r.source_port;
  assign out_if.dest_port          = res_r.dest_port;
  assign out_if.app_payload_length = res_r.app_payload_length;
  assign out_if.frame_wire_length  = res_r.frame_wire_length;

endmodule

/* sv/eftx_checker.sv */
// port-level checks on the result channel, bound to the top level
`include "ethernet_flow_tuple_extractor_core_defines.svh"

module eftx_checker
  import eftx_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [1:0]  flow_type,
  input logic [47:0] dest_mac,
  input logic [47:0] source_mac,
  input logic [63:0] source_ip_high,
  input logic [63:0] source_ip_low,
  input logic [63:0] dest_ip_high,
  input logic [63:0] dest_ip_low,
  input logic [15:0] source_port,
  input logic [15:0] dest_port,
  input logic [15:0] app_payload_length,
  input logic [15:0] frame_wire_length
);

  `EFTX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `EFTX_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(status) && $stable(flow_type) && $stable(app_payload_length) && $stable(frame_wire_length), "result changed while stalled")

  // a rejected frame carries nothing but its status and wire length
  `EFTX_ASSERT_NOW(a_reject_zero, out_valid && status != ST_ACCEPTED, flow_type == 2'd0 && dest_mac == '0 && source_mac == '0 && source_ip_high == '0 && source_ip_low == '0 && dest_ip_high == '0 && dest_ip_low == '0 && source_port == '0 && dest_port == '0 && app_payload_length == '0, "rejected frame has nonzero fields")

  // accepted frames have payload, and ipv4 flows leave the upper address halves empty
  `EFTX_ASSERT_NOW(a_accept_shape, out_valid && status == ST_ACCEPTED, app_payload_length != '0 && (flow_type[1] || (source_ip_high == '0 && dest_ip_high == '0)), "accepted frame has bad payload length or address")

endmodule

bind ethernet_flow_tuple_extractor_core eftx_checker u_eftx_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .status             (out_if.status),
  .flow_type          (out_if.flow_type),
  .dest_mac           (out_if.dest_mac),
  .source_mac         (out_if.source_mac),
  .source_ip_high     (out_if.source_ip_high),
  .source_ip_low      (out_if.source_ip_low),
  .dest_ip_high       (out_if.dest_ip_high),
  .dest_ip_low        (out_if.dest_ip_low),
  .source_port        (out_if.source_port),
  .dest_port          (out_if.dest_port),
  .app_payload_length (out_if.app_payload_length),
  .frame_wire_length  (out_if.frame_wire_length)
);
